// ===== rtl/serial_frame_deframer_core_defines.svh =====
// ---------------------------------------------------------------------------
// serial_frame_deframer_core_defines
// Assertion macros shared by the deframer RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SFD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, clk, rstn, prop, msg)
`define SFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfd_pkg
// Constants, status codes and inter-module types of the frame deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

	localparam int unsigned BUF_DEPTH_DEF = 32;

	localparam logic [7:0] ESC_BYTE  = 8'hFF;
	localparam logic [7:0] HEAD_BYTE = 8'hFA;
	localparam logic [7:0] TAIL_BYTE = 8'hFB;
	localparam logic [7:0] TLM_CLASS = 8'h16;
	localparam logic [7:0] TLM_ID    = 8'h02;
	localparam logic [7:0] TLM_LEN   = 8'h17;

	// payload bytes 0..21 are the only ones ever decoded
	localparam int unsigned NUM_CAP = 22;

	localparam int unsigned RES_BITS = 3 + 3 * 8 + 5 * 32;
	localparam int unsigned TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_TLM     = 3'd0,
		ST_OTHER   = 3'd1,
		ST_BAD_LEN = 3'd2,
		ST_BAD_SUM = 3'd3,
		ST_OVF     = 3'd4
	} status_t;

	typedef struct packed {
		logic                      fire;
		logic                      ovf;
		logic [7:0]                count;
		logic [7:0]                xsum;
		logic [NUM_CAP-1:0][7:0]   cap;
	} frame_info_t;

endpackage

// ===== rtl/sfd_parser.sv =====
// ---------------------------------------------------------------------------
// sfd_parser
// Input register, unstuffing state machine, length/XOR tracking and
// capture of the leading payload bytes.
// ---------------------------------------------------------------------------
module sfd_parser #(
	parameter int unsigned BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          s_tdata,   // rx_byte
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                out_free,
	output sfd_pkg::frame_info_t info
);
	import sfd_pkg::*;

	`include "serial_frame_deframer_core_defines.svh"

	typedef enum logic [1:0] {
		PS_HUNT,
		PS_HUNT_ESC,
		PS_DATA,
		PS_DATA_ESC
	} pstate_t;

	localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	pstate_t                 state_q;
	logic [7:0]              count_q;
	logic [7:0]              xor_q;
	logic                    ovf_q;
	logic [NUM_CAP-1:0][7:0] cap_q;

	logic tail_byte;
	logic adv;
	logic take;
	logic full;

	assign tail_byte = (state_q == PS_DATA_ESC) && (byte_s1 == TAIL_BYTE);
	assign adv       = valid_s1 && (!tail_byte || out_free);
	assign s_tready  = !valid_s1 || adv;
	assign take      = adv && (((state_q == PS_DATA) && (byte_s1 != ESC_BYTE)) ||
	                           ((state_q == PS_DATA_ESC) && (byte_s1 == ESC_BYTE)));
	assign full      = ovf_q || (9'(count_q) >= DEPTH9) || (count_q == 8'hFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_HUNT;
			count_q <= 8'd0;
			xor_q   <= 8'd0;
			ovf_q   <= 1'b0;
		end else if (adv) begin
			case (state_q)
				PS_HUNT: begin
					if (byte_s1 == ESC_BYTE) begin
						state_q <= PS_HUNT_ESC;
					end
				end
				PS_HUNT_ESC: begin
					if (byte_s1 == HEAD_BYTE) begin
						state_q <= PS_DATA;
						count_q <= 8'd0;
						xor_q   <= 8'd0;
						ovf_q   <= 1'b0;
					end else begin
						state_q <= PS_HUNT;
					end
				end
				PS_DATA: begin
					if (byte_s1 == ESC_BYTE) begin
						state_q <= PS_DATA_ESC;
					end
				end
				PS_DATA_ESC: begin
					if (byte_s1 == ESC_BYTE) begin
						state_q <= PS_DATA;
					end else if (byte_s1 == TAIL_BYTE) begin
						state_q <= PS_HUNT;
						count_q <= 8'd0;
						xor_q   <= 8'd0;
						ovf_q   <= 1'b0;
					end else begin
						state_q <= PS_HUNT;
					end
				end
				default: begin
					state_q <= PS_HUNT;
				end
			endcase
			if (take) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 8'd1;
					xor_q   <= xor_q ^ byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CAP; i++) begin
			if (take && !full && (count_q == 8'(i))) begin
				cap_q[i] <= byte_s1;
			end
		end
	end

	always_comb begin
		info.fire  = adv && tail_byte;
		info.ovf   = ovf_q;
		info.count = count_q;
		info.xsum  = xor_q;
		info.cap   = cap_q;
	end

	`SFD_ASSERT(a_count_bound, clk, arst_n, 9'(count_q) <= DEPTH9, "payload count past depth")
	`SFD_ASSERT(a_tail_clears, clk, arst_n, info.fire |=> (count_q == 8'd0) && !ovf_q, "tail did not restart frame")
	`SFD_ASSERT(a_empty_xor, clk, arst_n, (count_q == 8'd0) |-> (xor_q == 8'd0), "XOR set with no payload")

endmodule

// ===== rtl/sfd_result.sv =====
// ---------------------------------------------------------------------------
// sfd_result
// Frame checks, telemetry decode and the output result register.
// ---------------------------------------------------------------------------
module sfd_result (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfd_pkg::frame_info_t        info,
	output logic                        out_free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status, frame_length, frame_class, cmd_id, serial_number, left_speed,
	// left_distance, right_speed, right_distance, zero pad
	output logic [sfd_pkg::TDATA_W-1:0] m_tdata
);
	import sfd_pkg::*;

	`include "serial_frame_deframer_core_defines.svh"

	status_t     status_c;
	logic [7:0]  class_c;
	logic [7:0]  id_c;
	logic [31:0] sn_c;
	logic [31:0] ls_c;
	logic [31:0] ld_c;
	logic [31:0] rs_c;
	logic [31:0] rd_c;
	logic [31:0] ld_raw;
	logic [31:0] rd_raw;

	logic        valid_q;
	status_t     status_q;
	logic [7:0]  len_q;
	logic [7:0]  class_q;
	logic [7:0]  id_q;
	logic [31:0] sn_q;
	logic [31:0] ls_q;
	logic [31:0] ld_q;
	logic [31:0] rs_q;
	logic [31:0] rd_q;

	assign out_free = !valid_q || m_tready;

	always_comb begin
		class_c = (info.count >= 8'd1) ? info.cap[0] : 8'd0;
		id_c    = (info.count >= 8'd2) ? info.cap[1] : 8'd0;

		if (info.ovf) begin
			status_c = ST_OVF;
		end else if ((info.count == 8'd0) || (info.cap[0] != info.count - 8'd1)) begin
			status_c = ST_BAD_LEN;
		end else if (info.xsum != 8'd0) begin
			status_c = ST_BAD_SUM;
		end else if ((info.count >= 8'd2) && (info.cap[0] == TLM_CLASS) &&
		             (info.cap[1] == TLM_ID)) begin
			status_c = ST_TLM;
		end else begin
			status_c = ST_OTHER;
		end

		ld_raw = {info.cap[10], info.cap[11], info.cap[12], info.cap[13]};
		rd_raw = {info.cap[18], info.cap[19], info.cap[20], info.cap[21]};
		sn_c   = {info.cap[2], info.cap[3], info.cap[4], info.cap[5]};
		ls_c   = {info.cap[6], info.cap[7], info.cap[8], info.cap[9]};
		rs_c   = {info.cap[14], info.cap[15], info.cap[16], info.cap[17]};
		ld_c   = ls_c[31] ? (~ld_raw + 32'd1) : ld_raw;
		rd_c   = rs_c[31] ? (~rd_raw + 32'd1) : rd_raw;

		if (status_c != ST_TLM) begin
			sn_c = 32'd0;
			ls_c = 32'd0;
			ld_c = 32'd0;
			rs_c = 32'd0;
			rd_c = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (info.fire) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (info.fire) begin
			status_q <= status_c;
			len_q    <= info.count;
			class_q  <= class_c;
			id_q     <= id_c;
			sn_q     <= sn_c;
			ls_q     <= ls_c;
			ld_q     <= ld_c;
			rs_q     <= rs_c;
			rd_q     <= rd_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {(TDATA_W - RES_BITS)'(0), rd_q, rs_q, ld_q, ls_q, sn_q,
	                   id_q, class_q, len_q, status_q};

	`SFD_ASSERT(a_fields_zero, clk, arst_n, valid_q && (status_q != ST_TLM) |-> (sn_q == 32'd0) && (ls_q == 32'd0) && (ld_q == 32'd0) && (rs_q == 32'd0) && (rd_q == 32'd0), "decode fields set on non-telemetry frame")
	`SFD_ASSERT(a_tlm_shape, clk, arst_n, valid_q && (status_q == ST_TLM) |-> (class_q == TLM_CLASS) && (id_q == TLM_ID) && (len_q == TLM_LEN), "telemetry with wrong header")
	`SFD_ASSERT(a_empty_frame, clk, arst_n, valid_q && (len_q == 8'd0) |-> (class_q == 8'd0) && ((status_q == ST_BAD_LEN) || (status_q == ST_OVF)), "empty frame reported wrongly")

endmodule

// ===== rtl/serial_frame_deframer_core.sv =====
// ---------------------------------------------------------------------------
// serial_frame_deframer_core
// Byte-stuffed serial frame receiver with length and XOR checks.
// ---------------------------------------------------------------------------
// A tail byte passes the input register; its result is then registered onto m_tvalid.
// Throughput: one byte per cycle; a tail byte waits in the input register only while
// the result register holds an untaken result.
// Reset: arst_n clears the parser to hunting and empties both registers; captured
// payload bytes are not reset.
module serial_frame_deframer_core #(
	parameter int unsigned BUF_DEPTH = sfd_pkg::BUF_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  s_tdata,   // rx_byte
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// status, frame_length, frame_class, cmd_id, serial_number, left_speed,
	// left_distance, right_speed, right_distance, zero pad
	output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready
);
	import sfd_pkg::*;

	frame_info_t info;
	logic        out_free;

	sfd_parser #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_free (out_free),
		.info     (info)
	);

	sfd_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.info     (info),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
